>>> rtl/lmss_pkg.sv
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared constants, codes and controller/datapath bundles for the marked-line
// set with successor search.
// ----------------------------------------------------------------------------
package lmss_pkg;

  // Sizes
  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned LINE_BITS  = 16;
  localparam int unsigned ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W    = LINE_BITS + 1;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IN_USER_W  = OP_W + 1;
  localparam int unsigned IN_DATA_W  = ((LINE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((LINE_BITS + CNT_W + 7) / 8) * 8;

  // Opcodes; the decoder clears on either code with the high bit set
  localparam logic [OP_W-1:0] OP_TOGGLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT      = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ALT = 2'd3;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_REMOVED = 3'd1,
    ST_KIND    = 3'd2,
    ST_FULL    = 3'd3,
    ST_FOUND   = 3'd4,
    ST_WRAP    = 3'd5,
    ST_EMPTY   = 3'd6,
    ST_CLEARED = 3'd7
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted item, reset the scan
    logic scan;     // issue reads and compare entries
    logic resolve;  // settle the result, update count and memory
    logic move_rd;  // read the last entry
    logic move_wr;  // write the last entry into the freed slot
    logic emit;     // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quick;      // no scan needed (clear or empty set)
    logic scan_end;   // last entry compared or toggle hit
    logic need_move;  // removal leaves a hole below the last entry
    logic out_busy;   // output register still holds an unread item
  } sts_t;

endpackage

>>> rtl/lmss_ram.sv
// ----------------------------------------------------------------------------
// lmss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmss_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lmss_ctrl.sv
// ----------------------------------------------------------------------------
// lmss_ctrl
// Sequencer: accept an item, run the memory scan, settle the result, move
// the last entry on a removal, and hand the result to the output register.
// ----------------------------------------------------------------------------
module lmss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_tvalid_i,
  output logic          in_tready_o,
  input  lmss_pkg::sts_t sts_i,
  output lmss_pkg::cmd_t cmd_o
);
  import lmss_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_tready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.quick || sts_i.scan_end) begin
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = sts_i.need_move ? S_MOVE_RD : S_DONE;
      end
      S_MOVE_RD: begin
        cmd_o.move_rd = 1'b1;
        state_d       = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.move_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/lmss_dp.sv
// ----------------------------------------------------------------------------
// lmss_dp
// Datapath: item registers, mark count, entry memory, scan compare with
// successor and minimum tracking, result settling and the output register.
// ----------------------------------------------------------------------------
module lmss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lmss_pkg::cmd_t                cmd_i,
  output lmss_pkg::sts_t                sts_o,
  input  logic [lmss_pkg::OP_W-1:0]     op_i,
  input  logic [lmss_pkg::LINE_BITS-1:0] line_i,
  input  logic                          kind_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lmss_pkg::status_e             out_status_o,
  output logic [lmss_pkg::LINE_BITS-1:0] out_line_o,
  output logic [lmss_pkg::CNT_W-1:0]    out_count_o
);
  import lmss_pkg::*;

  // Item and set state
  logic [OP_W-1:0]      op_q;
  logic [LINE_BITS-1:0] line_q;
  logic                 kind_q;
  logic [CNT_W-1:0]     count_q, count_d;

  // Scan state
  logic [CNT_W-1:0]     iss_q, iss_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                 found_q, found_d;
  logic [ADDR_W-1:0]    found_idx_q, found_idx_d;
  logic                 found_kind_q, found_kind_d;
  logic                 have_succ_q, have_succ_d;
  logic [LINE_BITS-1:0] succ_q, succ_d;
  logic [LINE_BITS-1:0] least_q, least_d;

  // Result and output
  status_e              res_status_q, res_status_d;
  logic [LINE_BITS-1:0] res_line_q, res_line_d;
  logic                 out_vld_q, out_vld_d;
  status_e              out_status_q;
  logic [LINE_BITS-1:0] out_line_q;
  logic [CNT_W-1:0]     out_count_q;

  // Memory ports
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  // Decoded helpers
  logic                 is_clear;
  logic                 is_toggle;
  logic                 is_next;
  logic [CNT_W-1:0]     count_m1;
  logic [ADDR_W-1:0]    last_idx;
  logic [LINE_BITS-1:0] ent_line;
  logic                 ent_kind;
  logic                 ent_hit;
  logic                 issue;
  logic                 remove_hit;

  assign is_clear   = (op_q == OP_CLEAR) || (op_q == OP_CLEAR_ALT);
  assign is_toggle  = (op_q == OP_TOGGLE);
  assign is_next    = (op_q == OP_NEXT);
  assign count_m1   = count_q - CNT_W'(1);
  assign last_idx   = count_m1[ADDR_W-1:0];
  assign ent_line   = mem_rdata[LINE_BITS-1:0];
  assign ent_kind   = mem_rdata[LINE_BITS];
  assign ent_hit    = cmp_vld_q && is_toggle && (ent_line == line_q);
  assign issue      = cmd_i.scan && (iss_q < count_q);
  assign remove_hit = is_toggle && found_q && (found_kind_q == kind_q);

  // Status toward the controller
  assign sts_o.quick     = is_clear || (count_q == '0);
  assign sts_o.scan_end  = cmp_vld_q && ((cmp_idx_q == last_idx) || ent_hit);
  assign sts_o.need_move = remove_hit && (found_idx_q != last_idx);
  assign sts_o.out_busy  = out_vld_q && !out_ready_i;

  // Memory addressing: scan reads, last-entry read, writes on settle/move
  always_comb begin
    mem_raddr = iss_q[ADDR_W-1:0];
    if (cmd_i.move_rd) begin
      mem_raddr = count_q[ADDR_W-1:0];
    end
    mem_we    = 1'b0;
    mem_waddr = found_idx_q;
    mem_wdata = {kind_q, line_q};
    if (cmd_i.resolve && is_toggle && !remove_hit) begin
      if (found_q) begin
        mem_we = 1'b1;
      end else if (count_q < CNT_W'(CAPACITY)) begin
        mem_we    = 1'b1;
        mem_waddr = count_q[ADDR_W-1:0];
      end
    end
    if (cmd_i.move_wr) begin
      mem_we    = 1'b1;
      mem_wdata = mem_rdata;
    end
  end

  // Scan: issue one read a cycle, compare the entry that comes back
  always_comb begin
    iss_d        = iss_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_kind_d = found_kind_q;
    have_succ_d  = have_succ_q;
    succ_d       = succ_q;
    least_d      = least_q;
    if (cmd_i.load) begin
      iss_d       = '0;
      cmp_vld_d   = 1'b0;
      found_d     = 1'b0;
      have_succ_d = 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_d = issue;
      cmp_idx_d = iss_q[ADDR_W-1:0];
      if (issue) begin
        iss_d = iss_q + CNT_W'(1);
      end
      if (cmp_vld_q) begin
        if ((cmp_idx_q == '0) || (ent_line < least_q)) begin
          least_d = ent_line;
        end
        if ((ent_line > line_q) && (!have_succ_q || (ent_line < succ_q))) begin
          succ_d      = ent_line;
          have_succ_d = 1'b1;
        end
        if (ent_hit) begin
          found_d      = 1'b1;
          found_idx_d  = cmp_idx_q;
          found_kind_d = ent_kind;
        end
      end
    end
  end

  // Settle the result and the count
  always_comb begin
    count_d      = count_q;
    res_status_d = res_status_q;
    res_line_d   = res_line_q;
    if (cmd_i.resolve) begin
      res_line_d = line_q;
      if (is_clear) begin
        count_d      = '0;
        res_status_d = ST_CLEARED;
      end else if (is_next) begin
        if (count_q == '0) begin
          res_status_d = ST_EMPTY;
        end else if (have_succ_q) begin
          res_status_d = ST_FOUND;
          res_line_d   = succ_q;
        end else begin
          res_status_d = ST_WRAP;
          res_line_d   = least_q;
        end
      end else if (remove_hit) begin
        count_d      = count_m1;
        res_status_d = ST_REMOVED;
      end else if (found_q) begin
        res_status_d = ST_KIND;
      end else if (count_q < CNT_W'(CAPACITY)) begin
        count_d      = count_q + CNT_W'(1);
        res_status_d = ST_ADDED;
      end else begin
        res_status_d = ST_FULL;
      end
    end
  end

  // Output register: drop on take, load on emit
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_vld_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      have_succ_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      have_succ_q <= have_succ_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      line_q <= line_i;
      kind_q <= kind_i;
    end
    cmp_idx_q    <= cmp_idx_d;
    found_idx_q  <= found_idx_d;
    found_kind_q <= found_kind_d;
    succ_q       <= succ_d;
    least_q      <= least_d;
    res_status_q <= res_status_d;
    res_line_q   <= res_line_d;
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_line_q   <= res_line_q;
      out_count_q  <= count_q;
    end
  end

  // Entry memory: {kind, line}
  lmss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_line_o   = out_line_q;
  assign out_count_o  = out_count_q;

endmodule

>>> rtl/line_mark_set_with_successor_unit.sv
// ----------------------------------------------------------------------------
// line_mark_set_with_successor_unit
// Set of marked lines with a one-bit kind: toggle, successor query, clear.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------
//   s_axis   | in  | tvalid_i/tready_o  | tdata: mark_line; tuser: op, kind
//   m_axis   | out | tvalid_o/tready_i  | tdata: line, count; tuser: status
//
// One item at a time. A clear, or any item on an empty set, skips the memory
// scan and goes straight to settling. Otherwise the entries are read one per
// cycle over the single read port of the entry memory (a toggle stops at the
// matching entry); a removal below the last entry then moves the last entry
// into the freed slot. The next item is taken once the result is loaded into
// the output register.
// Reset clears the count and the control state, not the entry memory; entries
// at or above the count are never compared. A stalled result waits in the
// output register; the following result holds until that one is taken.
// ----------------------------------------------------------------------------
module line_mark_set_with_successor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item in
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lmss_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // [15:0] mark_line
  input  logic [lmss_pkg::IN_USER_W-1:0]  s_axis_tuser_i,   // [1:0] opcode, [2] mark_kind
  // item out
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lmss_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // [15:0] result_line,
                                                            // [24:16] entry_count
  output logic [lmss_pkg::STATUS_W-1:0]   m_axis_tuser_o    // [2:0] status
);
  import lmss_pkg::*;

  cmd_t                 cmd;
  sts_t                 sts;
  status_e              out_status;
  logic [LINE_BITS-1:0] out_line;
  logic [CNT_W-1:0]     out_count;

  lmss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid_i),
    .in_tready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser_i[OP_W-1:0]),
    .line_i       (s_axis_tdata_i[LINE_BITS-1:0]),
    .kind_i       (s_axis_tuser_i[OP_W]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_line_o   (out_line),
    .out_count_o  (out_count)
  );

  // Pack the result item
  assign m_axis_tdata_o = OUT_DATA_W'({out_count, out_line});
  assign m_axis_tuser_o = out_status;

endmodule

>>> tb/line_mark_set_with_successor_unit_tb.sv
// ----------------------------------------------------------------------------
// line_mark_set_with_successor_unit_tb
// Self-checking bench for the marked-line set. A directed table covers the
// extremes, every opcode and the corner cases. Random traffic follows, with
// one full-set fill sequence. Every result is compared against a behavioral
// model of the set, or for typed directed rows against the table entry.
// ----------------------------------------------------------------------------
module line_mark_set_with_successor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [LINE_BITS-1:0] line;
    logic                 kind;
  } mark_cmd_t;

  typedef struct packed {
    status_e              status;
    logic [LINE_BITS-1:0] line;
    logic [CNT_W-1:0]     count;
  } mark_res_t;

  typedef struct packed {
    logic [LINE_BITS-1:0] line;
    logic                 kind;
  } mark_entry_t;

  typedef struct {
    mark_cmd_t cmd;
    logic      typed;
    mark_res_t res;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;   // [15:0] mark_line
  logic [IN_USER_W-1:0]  s_axis_tuser_i;   // [1:0] opcode, [2] mark_kind
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // [15:0] result_line, [24:16] entry_count
  logic [STATUS_W-1:0]   m_axis_tuser_o;   // [2:0] status

  // Model state, expected results and bookkeeping
  mark_entry_t marks_q[$];
  mark_res_t   pending_results[$];
  step_row_t   step_q[$];
  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned peak_marks;
  int unsigned stall_cycles;
  int unsigned status_seen[8];

  line_mark_set_with_successor_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one operation to the model set and return its result
  function automatic mark_res_t apply_mark_op(input mark_cmd_t c);
    mark_res_t            r;
    mark_entry_t          e;
    int                   hit;
    bit                   have_succ;
    logic [LINE_BITS-1:0] succ;
    logic [LINE_BITS-1:0] least;
    r.line    = c.line;
    r.status  = ST_CLEARED;
    hit       = -1;
    have_succ = 1'b0;
    succ      = '0;
    least     = '0;
    if (c.op[1]) begin
      marks_q.delete();
      r.status = ST_CLEARED;
    end else if (c.op == OP_NEXT) begin
      if (marks_q.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        least = marks_q[0].line;
        foreach (marks_q[i]) begin
          if (marks_q[i].line < least) least = marks_q[i].line;
          if (marks_q[i].line > c.line && (!have_succ || marks_q[i].line < succ)) begin
            succ      = marks_q[i].line;
            have_succ = 1'b1;
          end
        end
        r.status = have_succ ? ST_FOUND : ST_WRAP;
        r.line   = have_succ ? succ : least;
      end
    end else begin
      foreach (marks_q[i]) if (marks_q[i].line == c.line) hit = i;
      if (hit >= 0) begin
        if (marks_q[hit].kind == c.kind) begin
          marks_q.delete(hit);
          r.status = ST_REMOVED;
        end else begin
          marks_q[hit].kind = c.kind;
          r.status = ST_KIND;
        end
      end else if (marks_q.size() < CAPACITY) begin
        e.line = c.line;
        e.kind = c.kind;
        marks_q.push_back(e);
        r.status = ST_ADDED;
      end else begin
        r.status = ST_FULL;
      end
    end
    r.count = CNT_W'(marks_q.size());
    if (marks_q.size() > peak_marks) peak_marks = marks_q.size();
    return r;
  endfunction

  // Random operation: mostly toggles and next queries around a window of lines
  function automatic mark_cmd_t random_mark_cmd(input logic [LINE_BITS-1:0] base);
    mark_cmd_t   c;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 62) c.op = OP_TOGGLE;
    else if (r < 96) c.op = OP_NEXT;
    else c.op = $urandom_range(1) ? OP_CLEAR : OP_CLEAR_ALT;
    c.kind = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 55) begin
      c.line = base + LINE_BITS'($urandom_range(47));
    end else if (r < 75 && marks_q.size() > 0) begin
      c.line = marks_q[$urandom_range(marks_q.size() - 1)].line;
      // nudge next queries around a held line
      if (c.op == OP_NEXT) c.line = c.line + LINE_BITS'($urandom_range(2)) - 1'b1;
    end else if (r < 85) begin
      case ($urandom_range(3))
        0:       c.line = '0;
        1:       c.line = LINE_BITS'(1);
        2:       c.line = '1 - 1'b1;
        default: c.line = '1;
      endcase
    end else begin
      c.line = LINE_BITS'($urandom());
    end
    return c;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [LINE_BITS-1:0] line,
                         input logic kind, input logic typed, input status_e st,
                         input logic [LINE_BITS-1:0] res_line, input int unsigned count);
    step_row_t row;
    row.cmd.op    = op;
    row.cmd.line  = line;
    row.cmd.kind  = kind;
    row.typed     = typed;
    row.res.status = st;
    row.res.line  = res_line;
    row.res.count = CNT_W'(count);
    step_q.push_back(row);
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, field, got, want);
    mismatches++;
  endtask

  // Present one item, with a random gap first; tvalid stays high on return
  task automatic send_mark_op(input mark_cmd_t c, input logic typed,
                              input mark_res_t typed_res);
    int unsigned gap;
    mark_res_t   want;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c.line;
    s_axis_tuser_i  <= {c.kind, c.op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    want = apply_mark_op(c);
    if (typed) want = typed_res;
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n);
    logic [LINE_BITS-1:0] base;
    mark_res_t            none;
    none = '0;
    base = LINE_BITS'($urandom());
    repeat (n) send_mark_op(random_mark_cmd(base), 1'b0, none);
  endtask

  // Fill the set to capacity, then poke at it while full
  task automatic run_fill();
    mark_cmd_t            c;
    mark_res_t            none;
    logic [LINE_BITS-1:0] offset;
    none   = '0;
    offset = LINE_BITS'($urandom());
    c.op   = OP_CLEAR;
    c.line = offset;
    c.kind = 1'b0;
    send_mark_op(c, 1'b0, none);
    for (int i = 0; i < CAPACITY; i++) begin
      c.op   = OP_TOGGLE;
      c.line = LINE_BITS'(i * 257) + offset;
      c.kind = 1'($urandom_range(1));
      send_mark_op(c, 1'b0, none);
    end
    repeat (32) begin
      c = random_mark_cmd(offset);
      if (c.op[1]) c.op = OP_NEXT;
      // keep the set near capacity: re-add right after a likely removal
      send_mark_op(c, 1'b0, none);
      if (c.op == OP_TOGGLE && marks_q.size() < CAPACITY) begin
        c.line = LINE_BITS'($urandom());
        send_mark_op(c, 1'b0, none);
      end
    end
  endtask

  // Result checker and receiver backpressure
  always @(posedge clk_i) begin
    mark_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      status_seen[m_axis_tuser_o]++;
      if (pending_results.size() == 0) begin
        report_mismatch("with no item pending, line", m_axis_tdata_o[15:0], 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o != want.status)
          report_mismatch("status", m_axis_tuser_o, want.status);
        if (m_axis_tdata_o[15:0] != want.line)
          report_mismatch("result_line", m_axis_tdata_o[15:0], want.line);
        if (m_axis_tdata_o[24:16] != want.count)
          report_mismatch("entry_count", m_axis_tdata_o[24:16], want.count);
      end
      results_seen++;
    end
    m_axis_tready_i <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stall_cycles);
      $display("line_mark_set_with_successor_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned directed_items;
    mismatches      = 0;
    items_sent      = 0;
    results_seen    = 0;
    peak_marks      = 0;
    stall_cycles    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    src_idle_pct    = 16;
    dst_idle_pct    = 73;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    m_axis_tready_i <= 1'b0;

    // Directed cases from an empty set
    add_row(OP_NEXT,      16'h1234, 1'b0, 1'b1, ST_EMPTY,   16'h1234, 0);
    add_row(OP_TOGGLE,    16'h0000, 1'b0, 1'b1, ST_ADDED,   16'h0000, 1);
    add_row(OP_TOGGLE,    16'hFFFF, 1'b1, 1'b1, ST_ADDED,   16'hFFFF, 2);
    add_row(OP_NEXT,      16'h0000, 1'b0, 1'b1, ST_FOUND,   16'hFFFF, 2);
    add_row(OP_NEXT,      16'hFFFF, 1'b0, 1'b1, ST_WRAP,    16'h0000, 2);
    add_row(OP_NEXT,      16'hFFFF, 1'b1, 1'b1, ST_WRAP,    16'h0000, 2);
    add_row(OP_TOGGLE,    16'h0000, 1'b1, 1'b1, ST_KIND,    16'h0000, 2);
    add_row(OP_TOGGLE,    16'h0000, 1'b1, 1'b1, ST_REMOVED, 16'h0000, 1);
    add_row(OP_TOGGLE,    16'h8000, 1'b0, 1'b1, ST_ADDED,   16'h8000, 2);
    add_row(OP_TOGGLE,    16'h7FFF, 1'b0, 1'b1, ST_ADDED,   16'h7FFF, 3);
    add_row(OP_NEXT,      16'h7FFF, 1'b1, 1'b0, ST_ADDED,   16'h0000, 0);
    add_row(OP_NEXT,      16'h8000, 1'b0, 1'b0, ST_ADDED,   16'h0000, 0);
    // removal from the middle of the stored entries
    add_row(OP_TOGGLE,    16'h8000, 1'b0, 1'b0, ST_ADDED,   16'h0000, 0);
    add_row(OP_NEXT,      16'h7FFF, 1'b0, 1'b0, ST_ADDED,   16'h0000, 0);
    add_row(OP_CLEAR,     16'hABCD, 1'b1, 1'b1, ST_CLEARED, 16'hABCD, 0);
    add_row(OP_NEXT,      16'h0000, 1'b0, 1'b1, ST_EMPTY,   16'h0000, 0);
    add_row(OP_TOGGLE,    16'h00FF, 1'b1, 1'b1, ST_ADDED,   16'h00FF, 1);
    add_row(OP_TOGGLE,    16'hFF00, 1'b0, 1'b1, ST_ADDED,   16'hFF00, 2);
    // opcode with both bits set clears as well
    add_row(OP_CLEAR_ALT, 16'h5555, 1'b0, 1'b1, ST_CLEARED, 16'h5555, 0);
    add_row(OP_TOGGLE,    16'hAAAA, 1'b1, 1'b1, ST_ADDED,   16'hAAAA, 1);
    add_row(OP_NEXT,      16'hAAAA, 1'b0, 1'b1, ST_WRAP,    16'hAAAA, 1);
    add_row(OP_NEXT,      16'hAAA9, 1'b1, 1'b1, ST_FOUND,   16'hAAAA, 1);
    add_row(OP_TOGGLE,    16'hAAAA, 1'b0, 1'b1, ST_KIND,    16'hAAAA, 1);
    add_row(OP_TOGGLE,    16'hAAAA, 1'b0, 1'b1, ST_REMOVED, 16'hAAAA, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (step_q[i]) send_mark_op(step_q[i].cmd, step_q[i].typed, step_q[i].res);
    directed_items = items_sent;
    drain_results();

    // Slow receiver, light sender gaps, with a full-set sequence
    run_random(60);
    run_fill();
    drain_results();

    // Slow sender, light receiver stalls
    src_idle_pct = 73;
    dst_idle_pct = 16;
    run_random(280);
    drain_results();

    // Back to back
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random(280);

    // Wait out the last results, then a quiet window for stray outputs
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d results for %0d items (%0d directed), largest set held %0d",
             results_seen, items_sent, directed_items, peak_marks);
    $display("added %0d removed %0d kind %0d full %0d found %0d wrap %0d empty %0d clear %0d",
             status_seen[ST_ADDED], status_seen[ST_REMOVED], status_seen[ST_KIND],
             status_seen[ST_FULL], status_seen[ST_FOUND], status_seen[ST_WRAP],
             status_seen[ST_EMPTY], status_seen[ST_CLEARED]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("line_mark_set_with_successor_unit verification clean");
    end else begin
      $display("line_mark_set_with_successor_unit verification failed");
    end
    $finish;
  end

endmodule

>>> line_mark_set_with_successor_unit.f
rtl/lmss_pkg.sv
rtl/lmss_ram.sv
rtl/lmss_ctrl.sv
rtl/lmss_dp.sv
rtl/line_mark_set_with_successor_unit.sv
tb/line_mark_set_with_successor_unit_tb.sv
